// ----- rtl/leb_pkg.sv -----
package leb_pkg;

  localparam int CNT_W  = 7;
  localparam int CHAR_W = 8;
  localparam int KEY_W  = 16;

  localparam logic [CHAR_W-1:0] ASC_ENTER    = 8'h0D;
  localparam logic [CHAR_W-1:0] ASC_ESC      = 8'h1B;
  localparam logic [CHAR_W-1:0] ASC_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] ASC_EXT      = 8'h00;
  localparam logic [CHAR_W-1:0] ASC_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] ASC_PRINT_HI = 8'h7F;

  localparam logic [CHAR_W-1:0] SC_LEFT  = 8'h4B;
  localparam logic [CHAR_W-1:0] SC_RIGHT = 8'h4D;
  localparam logic [CHAR_W-1:0] SC_HOME  = 8'h47;
  localparam logic [CHAR_W-1:0] SC_END   = 8'h4F;
  localparam logic [CHAR_W-1:0] SC_DEL   = 8'h53;

  localparam logic [CNT_W-1:0] MAX_LENGTH_RESET = 7'd64;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RM_RD = 6'b000010,
    S_RM_WR = 6'b000100,
    S_IN_RD = 6'b001000,
    S_IN_WR = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage

// ----- rtl/line_edit_buffer.sv -----
// One-line text editor driven by 16-bit PC key codes (scan code high, ASCII low).
// A key is taken when start is high and busy is low; every result word is shown
// for exactly one cycle with strobe high and cannot be held off by the receiver.
// Cursor keys, Escape, ignored keys and refused characters leave busy low, and the
// status word appears in the next cycle. The text lives in one single-port-per-direction
// memory, so shifting moves one character at a time, reading it in one state and
// writing it in the next: an insertion moves the characters from the cursor on up
// by one place, and a Backspace or Delete moves those after the removed one down.
// Enter on a non-empty line reads one character per cycle and emits line_length
// words, the last one with the last flag.
module line_edit_buffer
  import leb_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [KEY_W-1:0]  key_code,
  input  logic              cfg_write,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              strobe,
  output logic              kind,
  output logic [CHAR_W-1:0] char_out,
  output logic              last,
  output logic [CNT_W-1:0]  cursor_pos,
  output logic [CNT_W-1:0]  line_length,
  output logic              quit_request
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);

  state_t state;

  logic [CHAR_W-1:0] text_store [LINE_DEPTH];
  logic [CHAR_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;

  logic [CNT_W-1:0]  max_length;
  logic [CNT_W-1:0]  cursor;
  logic [CNT_W-1:0]  length;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  emit_n;
  logic [CHAR_W-1:0] ins_char;
  logic              out_strobe;
  logic              out_kind;
  logic              out_last;
  logic              out_quit;

  logic [CNT_W-1:0]  room;
  logic [CHAR_W-1:0] key_asc;
  logic [CHAR_W-1:0] key_scan;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_dec;

  assign room     = (max_length < DEPTH_C) ? max_length : DEPTH_C;
  assign key_asc  = key_code[CHAR_W-1:0];
  assign key_scan = key_code[KEY_W-1:CHAR_W];
  assign idx_inc  = idx + CNT_W'(1);
  assign idx_dec  = idx - CNT_W'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_RM_RD: begin
        rd_en   = (idx_inc < length);
        rd_addr = idx_inc[AW-1:0];
      end
      S_RM_WR: begin
        wr_en = 1'b1;
      end
      S_IN_RD: begin
        if (idx > cursor) begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[AW-1:0];
        end else begin
          wr_en   = 1'b1;
          wr_addr = cursor[AW-1:0];
          wr_data = ins_char;
        end
      end
      S_IN_WR: begin
        wr_en = 1'b1;
      end
      S_EMIT: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      text_store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= text_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor     <= '0;
      length     <= '0;
      idx        <= '0;
      emit_n     <= '0;
      ins_char   <= '0;
      out_strobe <= 1'b0;
      out_kind   <= 1'b0;
      out_last   <= 1'b0;
      out_quit   <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            out_strobe <= 1'b1;
            out_kind   <= 1'b0;
            out_last   <= 1'b1;
            out_quit   <= 1'b0;
            priority if (key_asc == ASC_ENTER) begin
              if (length != '0) begin
                out_strobe <= 1'b0;
                emit_n     <= length;
                idx        <= '0;
                length     <= '0;
                cursor     <= '0;
                state      <= S_EMIT;
              end
            end else if (key_asc == ASC_ESC) begin
              if (length != '0) begin
                length <= '0;
                cursor <= '0;
              end else begin
                out_quit <= 1'b1;
              end
            end else if (key_asc == ASC_BS) begin
              if (cursor != '0) begin
                out_strobe <= 1'b0;
                cursor     <= cursor - CNT_W'(1);
                idx        <= cursor - CNT_W'(1);
                state      <= S_RM_RD;
              end
            end else if (key_asc == ASC_EXT) begin
              priority if (key_scan == SC_LEFT) begin
                if (cursor != '0) begin
                  cursor <= cursor - CNT_W'(1);
                end
              end else if (key_scan == SC_RIGHT) begin
                if (cursor < length) begin
                  cursor <= cursor + CNT_W'(1);
                end
              end else if (key_scan == SC_HOME) begin
                cursor <= '0;
              end else if (key_scan == SC_END) begin
                cursor <= length;
              end else if (key_scan == SC_DEL) begin
                if (cursor < length) begin
                  out_strobe <= 1'b0;
                  idx        <= cursor;
                  state      <= S_RM_RD;
                end
              end else begin
              end
            end else if (key_asc >= ASC_PRINT_LO && key_asc < ASC_PRINT_HI &&
                         length < room) begin
              out_strobe <= 1'b0;
              ins_char   <= key_asc;
              idx        <= length;
              state      <= S_IN_RD;
            end else begin
            end
          end
        end
        S_RM_RD: begin
          if (idx_inc < length) begin
            state <= S_RM_WR;
          end else begin
            length     <= length - CNT_W'(1);
            out_strobe <= 1'b1;
            out_kind   <= 1'b0;
            out_last   <= 1'b1;
            out_quit   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_RM_WR: begin
          idx   <= idx_inc;
          state <= S_RM_RD;
        end
        S_IN_RD: begin
          if (idx > cursor) begin
            state <= S_IN_WR;
          end else begin
            cursor     <= cursor + CNT_W'(1);
            length     <= length + CNT_W'(1);
            out_strobe <= 1'b1;
            out_kind   <= 1'b0;
            out_last   <= 1'b1;
            out_quit   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_IN_WR: begin
          idx   <= idx_dec;
          state <= S_IN_RD;
        end
        S_EMIT: begin
          out_strobe <= 1'b1;
          out_kind   <= 1'b1;
          out_quit   <= 1'b0;
          out_last   <= (idx_inc == emit_n);
          idx        <= idx_inc;
          if (idx_inc == emit_n) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign strobe       = out_strobe;
  assign kind         = out_kind;
  assign char_out     = out_kind ? rd_data : '0;
  assign last         = out_last;
  assign cursor_pos   = cursor;
  assign line_length  = length;
  assign quit_request = out_quit;

  // The cursor never passes the end of the line, and the line never outgrows the store.
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= length)
    else $error("cursor beyond end of line");

  a_length_in_store: assert property (@(posedge clk) disable iff (rst)
    length <= DEPTH_C)
    else $error("line longer than store");

  // Status words always close their key, and sent characters report a cleared line.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !kind |-> last && char_out == '0)
    else $error("status word without last flag");

  a_emit_cleared: assert property (@(posedge clk) disable iff (rst)
    strobe && kind |-> cursor_pos == '0 && line_length == '0 && !quit_request)
    else $error("sent character with non-cleared line");

  // Quit is only requested for an empty line.
  a_quit_empty: assert property (@(posedge clk) disable iff (rst)
    strobe && quit_request |-> line_length == '0 && !kind)
    else $error("quit requested on non-empty line");

endmodule
